// File: rtl/ppp_pkg.sv
package ppp_pkg;

  // Field widths
  localparam int unsigned COORD_W    = 12;
  localparam int unsigned COLOR_W    = 4;
  localparam int unsigned ORIGIN_W   = 13;
  localparam int unsigned CFG_DATA_W = 13;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned OUT_ADDR_W = 20;
  localparam int unsigned BYTE_W     = 8;
  // Byte index before the store bound check: row (12 bits) times stride (11 bits) plus column
  localparam int unsigned ADDR_W     = 24;
  localparam int unsigned STRIDE_W   = 11;
  localparam int unsigned PROD_W     = 23;

  // Store sizes
  localparam int unsigned MAIN_BYTES_DEF = 1048576;
  localparam int unsigned RED_BYTES_DEF  = 65536;

  // Queue between front and back
  localparam int unsigned Q_DEPTH = 4;

  // Register reset values
  localparam logic [COORD_W-1:0] WIDTH_RST  = 12'd1200;
  localparam logic [COORD_W-1:0] HEIGHT_RST = 12'd1600;

  // Byte merge masks
  localparam logic [BYTE_W-1:0] LO_NIBBLE = 8'h0F;
  localparam logic [BYTE_W-1:0] HI_NIBBLE = 8'hF0;
  localparam logic [BYTE_W-1:0] MSB_MASK  = 8'h80;

  // Color codes in bitplane mode
  localparam logic [COLOR_W-1:0] COLOR_BLACK = 4'd1;

  typedef enum logic [1:0] {
    MODE_FLIP   = 2'd0,
    MODE_ROT    = 2'd1,
    MODE_PLANES = 2'd2
  } panel_mode_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_MODE     = 3'd0,
    REG_ROTATION = 3'd1,
    REG_ORIGIN_X = 3'd2,
    REG_ORIGIN_Y = 3'd3,
    REG_WIDTH    = 3'd4,
    REG_HEIGHT   = 3'd5
  } cfg_reg_e;

  typedef enum logic [1:0] {
    ROT_0   = 2'd0,
    ROT_90  = 2'd1,
    ROT_180 = 2'd2,
    ROT_270 = 2'd3
  } rotation_e;

  typedef enum logic {
    ST_CLEAR = 1'b0,
    ST_RUN   = 1'b1
  } back_state_e;

  typedef struct packed {
    logic [1:0]                 panel_mode;
    logic [1:0]                 rotation;
    logic signed [ORIGIN_W-1:0] origin_x;
    logic signed [ORIGIN_W-1:0] origin_y;
    logic [COORD_W-1:0]         panel_width;
    logic [COORD_W-1:0]         panel_height;
  } cfg_t;

  // One classified pixel waiting for its read-modify-write
  typedef struct packed {
    logic               ok;
    logic               planes;
    logic [ADDR_W-1:0]  addr;
    logic [2:0]         pos;
    logic [COLOR_W-1:0] color;
  } entry_t;

endpackage

// File: rtl/ppp_ram.sv
module ppp_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: rtl/ppp_front.sv
module ppp_front #(
  parameter int unsigned MAIN_BYTES = ppp_pkg::MAIN_BYTES_DEF,
  parameter int unsigned RED_BYTES  = ppp_pkg::RED_BYTES_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  ppp_pkg::cfg_t                 cfg_i,
  input  logic                          busy_i,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [ppp_pkg::COORD_W-1:0]   pixel_x_i,
  input  logic [ppp_pkg::COORD_W-1:0]   pixel_y_i,
  input  logic [ppp_pkg::COLOR_W-1:0]   color_code_i,
  input  logic                          q_full_i,
  output logic                          push_o,
  output ppp_pkg::entry_t               entry_o
);
  import ppp_pkg::*;

  logic                adv;
  logic                in_fire;

  // Stage 1 combinational: offset, clip, map
  logic [13:0]         lx;
  logic [13:0]         ly;
  logic [14:0]         py_rot;
  logic [COORD_W-1:0]  lw;
  logic [COORD_W-1:0]  lh;
  logic                ok_s1;
  logic                planes_s1;
  logic [COORD_W-1:0]  px_s1;
  logic [COORD_W-1:0]  py_s1;
  logic [STRIDE_W-1:0] stride_s1;

  // Stage 1 registers
  logic                s1_valid_q, s1_valid_d;
  logic                s1_ok_q;
  logic                s1_planes_q;
  logic [COORD_W-1:0]  s1_px_q;
  logic [COORD_W-1:0]  s1_py_q;
  logic [STRIDE_W-1:0] s1_stride_q;
  logic [COLOR_W-1:0]  s1_color_q;

  // Stage 2 registers
  logic                s2_valid_q, s2_valid_d;
  logic                s2_ok_q;
  logic                s2_planes_q;
  logic [PROD_W-1:0]   s2_prod_q;
  logic [STRIDE_W-1:0] s2_col_q;
  logic [2:0]          s2_pos_q;
  logic [COLOR_W-1:0]  s2_color_q;

  logic [ADDR_W-1:0]   idx;
  logic                in_store;

  assign adv        = !s2_valid_q || !q_full_i;
  assign in_stall_o = busy_i || !adv;
  assign in_fire    = in_valid_i && !in_stall_o;

  always_comb begin
    lx = {cfg_i.origin_x[ORIGIN_W-1], cfg_i.origin_x} + {2'b00, pixel_x_i};
    ly = {cfg_i.origin_y[ORIGIN_W-1], cfg_i.origin_y} + {2'b00, pixel_y_i};
    lw = cfg_i.rotation[0] ? cfg_i.panel_height : cfg_i.panel_width;
    lh = cfg_i.rotation[0] ? cfg_i.panel_width : cfg_i.panel_height;
    // Rotated nibble mode: row counts down from the right edge
    py_rot = {3'b000, cfg_i.panel_width} - 15'd1 - {lx[13], lx};
    ok_s1     = 1'b0;
    planes_s1 = 1'b0;
    px_s1     = '0;
    py_s1     = '0;
    case (panel_mode_e'(cfg_i.panel_mode))
      MODE_FLIP: begin
        ok_s1 = !lx[13] && !ly[13] && (lx[12:0] < {1'b0, cfg_i.panel_width})
                && (ly[12:0] < {1'b0, cfg_i.panel_height});
        px_s1 = cfg_i.panel_width - 12'd1 - lx[11:0];
        py_s1 = cfg_i.panel_height - 12'd1 - ly[11:0];
      end
      MODE_ROT: begin
        ok_s1 = !ly[13] && (ly[12:0] < {1'b0, cfg_i.panel_width})
                && !py_rot[14] && (py_rot[13:0] < {2'b00, cfg_i.panel_height});
        px_s1 = ly[11:0];
        py_s1 = py_rot[11:0];
      end
      MODE_PLANES: begin
        planes_s1 = 1'b1;
        ok_s1 = !lx[13] && !ly[13] && (lx[12:0] < {1'b0, lw}) && (ly[12:0] < {1'b0, lh});
        case (rotation_e'(cfg_i.rotation))
          ROT_0: begin
            px_s1 = lw - lx[11:0] - 12'd1;
            py_s1 = lh - ly[11:0] - 12'd1;
          end
          ROT_90: begin
            px_s1 = lh - ly[11:0] - 12'd1;
            py_s1 = lx[11:0];
          end
          ROT_180: begin
            px_s1 = lx[11:0];
            py_s1 = ly[11:0];
          end
          default: begin
            px_s1 = ly[11:0];
            py_s1 = lw - lx[11:0] - 12'd1;
          end
        endcase
      end
      default: begin
        ok_s1 = 1'b0;
      end
    endcase
    // Bytes per row: width/8 for bitplanes, width/2 for nibbles
    stride_s1 = planes_s1 ? {2'b00, cfg_i.panel_width[11:3]} : cfg_i.panel_width[11:1];
  end

  assign s1_valid_d = adv ? in_fire : s1_valid_q;
  assign s2_valid_d = adv ? s1_valid_q : s2_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s2_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= s1_valid_d;
      s2_valid_q <= s2_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s1_ok_q     <= ok_s1;
      s1_planes_q <= planes_s1;
      s1_px_q     <= px_s1;
      s1_py_q     <= py_s1;
      s1_stride_q <= stride_s1;
      s1_color_q  <= color_code_i;

      s2_ok_q     <= s1_ok_q;
      s2_planes_q <= s1_planes_q;
      s2_prod_q   <= s1_py_q * s1_stride_q;
      s2_col_q    <= s1_planes_q ? {2'b00, s1_px_q[11:3]} : s1_px_q[11:1];
      s2_pos_q    <= s1_px_q[2:0];
      s2_color_q  <= s1_color_q;
    end
  end

  // Byte index and store bound check
  assign idx      = {1'b0, s2_prod_q} + {{(ADDR_W-STRIDE_W){1'b0}}, s2_col_q};
  assign in_store = (idx < ADDR_W'(MAIN_BYTES)) && (!s2_planes_q || (idx < ADDR_W'(RED_BYTES)));

  assign push_o        = s2_valid_q && !q_full_i;
  assign entry_o.ok     = s2_ok_q && in_store;
  assign entry_o.planes = s2_planes_q;
  assign entry_o.addr   = idx;
  assign entry_o.pos    = s2_pos_q;
  assign entry_o.color  = s2_color_q;

endmodule

// File: rtl/ppp_queue.sv
module ppp_queue (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  ppp_pkg::entry_t entry_i,
  output logic            full_o,
  input  logic            pop_i,
  output logic            valid_o,
  output ppp_pkg::entry_t entry_o
);
  import ppp_pkg::*;

  localparam int unsigned AW = $clog2(Q_DEPTH);
  localparam int unsigned CW = $clog2(Q_DEPTH + 1);

  entry_t          slot_q [Q_DEPTH];
  logic [AW-1:0]   wptr_q, wptr_d;
  logic [AW-1:0]   rptr_q, rptr_d;
  logic [CW-1:0]   count_q, count_d;

  assign full_o  = (count_q == CW'(Q_DEPTH));
  assign valid_o = (count_q != '0);
  assign entry_o = slot_q[rptr_q];

  always_comb begin
    wptr_d  = wptr_q;
    rptr_d  = rptr_q;
    count_d = count_q;
    if (push_i) begin
      wptr_d = (wptr_q == AW'(Q_DEPTH - 1)) ? '0 : wptr_q + AW'(1);
    end
    if (pop_i) begin
      rptr_d = (rptr_q == AW'(Q_DEPTH - 1)) ? '0 : rptr_q + AW'(1);
    end
    if (push_i && !pop_i) begin
      count_d = count_q + CW'(1);
    end else if (pop_i && !push_i) begin
      count_d = count_q - CW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q  <= '0;
      rptr_q  <= '0;
      count_q <= '0;
    end else begin
      wptr_q  <= wptr_d;
      rptr_q  <= rptr_d;
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wptr_q] <= entry_i;
    end
  end

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    full_o |-> !push_i)
    else $error("queue pushed while full");

  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> valid_o)
    else $error("queue popped while empty");

endmodule

// File: rtl/ppp_back.sv
module ppp_back #(
  parameter int unsigned MAIN_BYTES = ppp_pkg::MAIN_BYTES_DEF,
  parameter int unsigned RED_BYTES  = ppp_pkg::RED_BYTES_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  output logic                            busy_o,
  input  logic                            q_valid_i,
  input  ppp_pkg::entry_t                 q_entry_i,
  output logic                            q_pop_o,
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output logic                            written_o,
  output logic [ppp_pkg::OUT_ADDR_W-1:0]  byte_address_o,
  output logic [ppp_pkg::BYTE_W-1:0]      primary_byte_o,
  output logic [ppp_pkg::BYTE_W-1:0]      red_plane_byte_o
);
  import ppp_pkg::*;

  localparam int unsigned MAIN_AW   = $clog2(MAIN_BYTES);
  localparam int unsigned RED_AW    = $clog2(RED_BYTES);
  localparam int unsigned CLR_DEPTH = (MAIN_BYTES > RED_BYTES) ? MAIN_BYTES : RED_BYTES;
  localparam int unsigned CLR_W     = $clog2(CLR_DEPTH);

  back_state_e         state_q, state_d;
  logic [CLR_W-1:0]    clr_cnt_q, clr_cnt_d;
  logic                clearing;
  logic                clr_main;
  logic                clr_red;

  entry_t              b2_q;
  logic                b2_valid_q, b2_valid_d;
  logic                b2_adv;

  logic                main_we;
  logic [MAIN_AW-1:0]  main_waddr;
  logic [BYTE_W-1:0]   main_wdata;
  logic [BYTE_W-1:0]   main_rdata;
  logic                red_we;
  logic [RED_AW-1:0]   red_waddr;
  logic [BYTE_W-1:0]   red_wdata;
  logic [BYTE_W-1:0]   red_rdata;

  // Last committed write of each store, for the read that overlaps it
  logic                lwm_valid_q;
  logic [MAIN_AW-1:0]  lwm_addr_q;
  logic [BYTE_W-1:0]   lwm_data_q;
  logic                lwr_valid_q;
  logic [RED_AW-1:0]   lwr_addr_q;
  logic [BYTE_W-1:0]   lwr_data_q;

  logic [BYTE_W-1:0]   main_old;
  logic [BYTE_W-1:0]   red_old;
  logic [BYTE_W-1:0]   mask;
  logic [BYTE_W-1:0]   new_main;
  logic [BYTE_W-1:0]   new_red;

  logic                out_valid_q, out_valid_d;
  logic                written_q;
  logic [OUT_ADDR_W-1:0] addr_q;
  logic [BYTE_W-1:0]   prim_q;
  logic [BYTE_W-1:0]   red_q;

  // Clearing sweep after reset
  always_comb begin
    state_d   = state_q;
    clr_cnt_d = clr_cnt_q;
    case (state_q)
      ST_CLEAR: begin
        if (clr_cnt_q == CLR_W'(CLR_DEPTH - 1)) begin
          state_d = ST_RUN;
        end else begin
          clr_cnt_d = clr_cnt_q + CLR_W'(1);
        end
      end
      ST_RUN: begin
        state_d = ST_RUN;
      end
      default: begin
        state_d = ST_CLEAR;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_CLEAR;
      clr_cnt_q <= '0;
    end else begin
      state_q   <= state_d;
      clr_cnt_q <= clr_cnt_d;
    end
  end

  assign clearing = (state_q == ST_CLEAR);
  assign busy_o   = clearing;
  assign clr_main = clearing && ({1'b0, clr_cnt_q} < (CLR_W + 1)'(MAIN_BYTES));
  assign clr_red  = clearing && ({1'b0, clr_cnt_q} < (CLR_W + 1)'(RED_BYTES));

  // Pipeline control
  assign b2_adv     = b2_valid_q && (!out_valid_q || !out_stall_i);
  assign q_pop_o    = !clearing && q_valid_i && (!b2_valid_q || b2_adv);
  assign b2_valid_d = q_pop_o ? 1'b1 : (b2_adv ? 1'b0 : b2_valid_q);
  assign out_valid_d = b2_adv ? 1'b1 : (out_valid_q && out_stall_i);

  // Merge
  always_comb begin
    main_old = (lwm_valid_q && (lwm_addr_q == b2_q.addr[MAIN_AW-1:0])) ? lwm_data_q
                                                                        : main_rdata;
    red_old  = (lwr_valid_q && (lwr_addr_q == b2_q.addr[RED_AW-1:0])) ? lwr_data_q
                                                                      : red_rdata;
    mask     = MSB_MASK >> b2_q.pos;
    new_red  = '0;
    if (b2_q.planes) begin
      new_main = main_old | mask;
      new_red  = red_old | mask;
      if (b2_q.color == COLOR_BLACK) begin
        new_main = new_main & ~mask;
      end else if (b2_q.color > COLOR_BLACK) begin
        new_red = new_red & ~mask;
      end
    end else if (!b2_q.pos[0]) begin
      new_main = (main_old & LO_NIBBLE) | {b2_q.color, 4'h0};
    end else begin
      new_main = (main_old & HI_NIBBLE) | {4'h0, b2_q.color};
    end
  end

  // Store ports: sweep zeros while clearing, commit merges afterwards
  assign main_we    = clearing ? clr_main : (b2_adv && b2_q.ok);
  assign main_waddr = clearing ? clr_cnt_q[MAIN_AW-1:0] : b2_q.addr[MAIN_AW-1:0];
  assign main_wdata = clearing ? '0 : new_main;
  assign red_we     = clearing ? clr_red : (b2_adv && b2_q.ok && b2_q.planes);
  assign red_waddr  = clearing ? clr_cnt_q[RED_AW-1:0] : b2_q.addr[RED_AW-1:0];
  assign red_wdata  = clearing ? '0 : new_red;

  ppp_ram #(
    .WIDTH (BYTE_W),
    .DEPTH (MAIN_BYTES)
  ) u_main_ram (
    .clk_i   (clk_i),
    .we_i    (main_we),
    .waddr_i (main_waddr),
    .wdata_i (main_wdata),
    .re_i    (q_pop_o),
    .raddr_i (q_entry_i.addr[MAIN_AW-1:0]),
    .rdata_o (main_rdata)
  );

  ppp_ram #(
    .WIDTH (BYTE_W),
    .DEPTH (RED_BYTES)
  ) u_red_ram (
    .clk_i   (clk_i),
    .we_i    (red_we),
    .waddr_i (red_waddr),
    .wdata_i (red_wdata),
    .re_i    (q_pop_o),
    .raddr_i (q_entry_i.addr[RED_AW-1:0]),
    .rdata_o (red_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b2_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      lwm_valid_q <= 1'b0;
      lwr_valid_q <= 1'b0;
    end else begin
      b2_valid_q  <= b2_valid_d;
      out_valid_q <= out_valid_d;
      if (!clearing && main_we) begin
        lwm_valid_q <= 1'b1;
      end
      if (!clearing && red_we) begin
        lwr_valid_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (q_pop_o) begin
      b2_q <= q_entry_i;
    end
    if (!clearing && main_we) begin
      lwm_addr_q <= main_waddr;
      lwm_data_q <= main_wdata;
    end
    if (!clearing && red_we) begin
      lwr_addr_q <= red_waddr;
      lwr_data_q <= red_wdata;
    end
    if (b2_adv) begin
      written_q <= b2_q.ok;
      addr_q    <= b2_q.ok ? b2_q.addr[OUT_ADDR_W-1:0] : '0;
      prim_q    <= b2_q.ok ? new_main : '0;
      red_q     <= (b2_q.ok && b2_q.planes) ? new_red : '0;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign written_o        = written_q;
  assign byte_address_o   = addr_q;
  assign primary_byte_o   = prim_q;
  assign red_plane_byte_o = red_q;

  a_no_pop_while_clearing: assert property (@(posedge clk_i) disable iff (!rst_ni)
    clearing |-> (!q_pop_o && !b2_valid_q && !out_valid_q))
    else $error("pixel in flight during store clearing");

  a_dropped_word_is_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !written_q) |->
      (addr_q == '0 && prim_q == '0 && red_q == '0))
    else $error("dropped pixel reported nonzero payload");

  a_red_only_in_planes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!clearing && red_we) |-> (b2_adv && b2_q.planes))
    else $error("red plane written outside bitplane mode");

endmodule

// File: rtl/panel_pixel_packer.sv
// Panel pixel packer. Each input word is one pixel (pixel_x, pixel_y, color_code); the block
// adds the signed origin, clips against the panel, maps the point to a physical byte and
// merges the color into that byte of the on-chip frame stores, then returns one output
// word with the new byte values (written low and all fields zero when the pixel was
// clipped or fell past a store). Mode 0 flips by 180 degrees and packs nibbles, mode 1
// maps rotated nibbles, mode 2 honors the rotation register and updates a black/white
// plane and a red plane, MSB first. Throughput is one pixel per clock, sustained while
// out_stall_i is low: each pixel is a single read-modify-write of one byte, and a
// one-entry bypass of the last committed write per store lets back-to-back pixels hit
// the same byte. Without stalls, the input accept edge loads the first of two front
// stages (offset, clip and map; then row times stride), followed by the four-entry
// queue, the store read and the output register, which raises output valid. After
// reset the block sweeps zeros through every byte of both stores with in_stall_o high;
// configuration writes are taken during the sweep. Write configuration only while no
// pixel is in flight.
module panel_pixel_packer #(
  parameter int unsigned MAIN_BYTES = ppp_pkg::MAIN_BYTES_DEF,
  parameter int unsigned RED_BYTES  = ppp_pkg::RED_BYTES_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  // configuration
  input  logic                            cfg_we_i,
  input  logic [ppp_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [ppp_pkg::CFG_DATA_W-1:0]  cfg_data_i,
  // pixel input
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  logic [ppp_pkg::COORD_W-1:0]     pixel_x_i,
  input  logic [ppp_pkg::COORD_W-1:0]     pixel_y_i,
  input  logic [ppp_pkg::COLOR_W-1:0]     color_code_i,
  // result output
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output logic                            written_o,
  output logic [ppp_pkg::OUT_ADDR_W-1:0]  byte_address_o,
  output logic [ppp_pkg::BYTE_W-1:0]      primary_byte_o,
  output logic [ppp_pkg::BYTE_W-1:0]      red_plane_byte_o
);
  import ppp_pkg::*;

  cfg_t   cfg_q;
  logic   busy;
  logic   q_full;
  logic   q_push;
  logic   q_pop;
  logic   q_valid;
  entry_t front_entry;
  entry_t q_entry;

  // Configuration registers: take the low bits of the write data for narrow registers,
  // ignore indexes past the list.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.panel_mode   <= MODE_FLIP;
      cfg_q.rotation     <= ROT_0;
      cfg_q.origin_x     <= '0;
      cfg_q.origin_y     <= '0;
      cfg_q.panel_width  <= WIDTH_RST;
      cfg_q.panel_height <= HEIGHT_RST;
    end else if (cfg_we_i) begin
      case (cfg_reg_e'(cfg_idx_i))
        REG_MODE:     cfg_q.panel_mode   <= cfg_data_i[1:0];
        REG_ROTATION: cfg_q.rotation     <= cfg_data_i[1:0];
        REG_ORIGIN_X: cfg_q.origin_x     <= cfg_data_i;
        REG_ORIGIN_Y: cfg_q.origin_y     <= cfg_data_i;
        REG_WIDTH:    cfg_q.panel_width  <= cfg_data_i[COORD_W-1:0];
        REG_HEIGHT:   cfg_q.panel_height <= cfg_data_i[COORD_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // Front: accept, offset, clip, map and compute the byte index
  ppp_front #(
    .MAIN_BYTES (MAIN_BYTES),
    .RED_BYTES  (RED_BYTES)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg_q),
    .busy_i       (busy),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .pixel_x_i    (pixel_x_i),
    .pixel_y_i    (pixel_y_i),
    .color_code_i (color_code_i),
    .q_full_i     (q_full),
    .push_o       (q_push),
    .entry_o      (front_entry)
  );

  // Decouple the front from store access and output stalls
  ppp_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .entry_i (front_entry),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .valid_o (q_valid),
    .entry_o (q_entry)
  );

  // Back: read-modify-write of the frame stores and the output register
  ppp_back #(
    .MAIN_BYTES (MAIN_BYTES),
    .RED_BYTES  (RED_BYTES)
  ) u_back (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .busy_o           (busy),
    .q_valid_i        (q_valid),
    .q_entry_i        (q_entry),
    .q_pop_o          (q_pop),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .written_o        (written_o),
    .byte_address_o   (byte_address_o),
    .primary_byte_o   (primary_byte_o),
    .red_plane_byte_o (red_plane_byte_o)
  );

endmodule

// File: tb/panel_pixel_packer_test.sv
`timescale 1ns / 1ps

module panel_pixel_packer_test;
  import ppp_pkg::*;

  // Mode code that the package leaves unnamed; the block must answer "not written"
  localparam logic [1:0] MODE_UNUSED = 2'd3;
  // Random pixel count after the directed part
  localparam int unsigned RANDOM_ITEMS = 600;
  // Cycles with no word moving on either side before the run is declared hung.
  // The limit must outlast the zero sweep after reset.
  localparam int unsigned QUIET_LIMIT = 4 * MAIN_BYTES_DEF;
  // Pipeline is five deep; pad generously after the last expected word
  localparam int unsigned SETTLE_CYCLES = 12;

  typedef struct packed {
    logic                  written;
    logic [OUT_ADDR_W-1:0] byte_address;
    logic [BYTE_W-1:0]     primary_byte;
    logic [BYTE_W-1:0]     red_plane_byte;
  } pixel_word_t;

  // Mirror of the frame stores and registers; predicts the word for each pixel
  class frame_model;
    logic [1:0]  mode;
    rotation_e   rot;
    longint      org_x, org_y, width, height;
    logic [7:0]  main_mem [longint];
    logic [7:0]  red_mem [longint];
    pixel_word_t expected_words [$];
    int unsigned errors;

    function new();
      mode   = MODE_FLIP;
      rot    = ROT_0;
      org_x  = 0;
      org_y  = 0;
      width  = longint'(WIDTH_RST);
      height = longint'(HEIGHT_RST);
      errors = 0;
    endfunction

    function void set_reg(cfg_reg_e idx, logic [CFG_DATA_W-1:0] data);
      case (idx)
        REG_MODE:     mode   = data[1:0];
        REG_ROTATION: rot    = rotation_e'(data[1:0]);
        REG_ORIGIN_X: org_x  = longint'($signed(data));
        REG_ORIGIN_Y: org_y  = longint'($signed(data));
        REG_WIDTH:    width  = longint'(data[COORD_W-1:0]);
        REG_HEIGHT:   height = longint'(data[COORD_W-1:0]);
        default: ;
      endcase
    endfunction

    // Nibble packing shared by the flip and rotated modes
    function void merge_nibble(longint px, longint py, logic [3:0] color,
                               inout pixel_word_t w);
      longint     idx;
      logic [7:0] b;
      idx = py * (width / 2) + (px >>> 1);
      if (idx < 0 || idx >= longint'(MAIN_BYTES_DEF)) return;
      b = main_mem.exists(idx) ? main_mem[idx] : 8'h00;
      if (px[0] == 1'b0) b = (b & LO_NIBBLE) | {color, 4'h0};
      else               b = (b & HI_NIBBLE) | {4'h0, color};
      main_mem[idx]    = b;
      w.written        = 1'b1;
      w.byte_address   = idx[OUT_ADDR_W-1:0];
      w.primary_byte   = b;
      w.red_plane_byte = 8'h00;
    endfunction

    function void merge_planes(longint lx, longint ly, logic [3:0] color,
                               inout pixel_word_t w);
      longint     lw, lh, px, py, idx;
      logic [7:0] mask, m, r;
      lw = rot[0] ? height : width;
      lh = rot[0] ? width : height;
      if (lx < 0 || ly < 0 || lx >= lw || ly >= lh) return;
      case (rot)
        ROT_0:   begin px = lw - lx - 1; py = lh - ly - 1; end
        ROT_90:  begin px = lh - ly - 1; py = lx;          end
        ROT_180: begin px = lx;          py = ly;          end
        default: begin px = ly;          py = lw - lx - 1; end
      endcase
      idx = (width / 8) * py + px / 8;
      if (idx < 0 || idx >= longint'(MAIN_BYTES_DEF) || idx >= longint'(RED_BYTES_DEF)) return;
      mask = MSB_MASK >> px[2:0];
      m = (main_mem.exists(idx) ? main_mem[idx] : 8'h00) | mask;
      r = (red_mem.exists(idx) ? red_mem[idx] : 8'h00) | mask;
      if (color == COLOR_BLACK)     m = m & ~mask;
      else if (color > COLOR_BLACK) r = r & ~mask;
      main_mem[idx]    = m;
      red_mem[idx]     = r;
      w.written        = 1'b1;
      w.byte_address   = idx[OUT_ADDR_W-1:0];
      w.primary_byte   = m;
      w.red_plane_byte = r;
    endfunction

    function void note_pixel(logic [COORD_W-1:0] x, logic [COORD_W-1:0] y,
                             logic [COLOR_W-1:0] color);
      longint      xi, yi, px, py;
      pixel_word_t w;
      w  = '0;
      xi = longint'(x);
      yi = longint'(y);
      case (mode)
        MODE_FLIP: begin
          if (org_x + xi >= 0 && org_y + yi >= 0 && org_x + xi < width && org_y + yi < height)
            merge_nibble(width - 1 - org_x - xi, height - 1 - org_y - yi, color, w);
        end
        MODE_ROT: begin
          px = org_y + yi;
          py = width - 1 - org_x - xi;
          if (px >= 0 && px < width && py >= 0 && py < height)
            merge_nibble(px, py, color, w);
        end
        MODE_PLANES: merge_planes(org_x + xi, org_y + yi, color, w);
        default: ;
      endcase
      expected_words.push_back(w);
    endfunction

    function void check_word(pixel_word_t got);
      pixel_word_t exp_w;
      if (expected_words.size() == 0) begin
        $error("output word with no pixel pending");
        errors++;
        return;
      end
      exp_w = expected_words.pop_front();
      if (got.written !== exp_w.written) begin
        $error("written: expected %0d, got %0d", exp_w.written, got.written);
        errors++;
      end
      if (got.byte_address !== exp_w.byte_address) begin
        $error("byte_address: expected 0x%05h, got 0x%05h", exp_w.byte_address,
               got.byte_address);
        errors++;
      end
      if (got.primary_byte !== exp_w.primary_byte) begin
        $error("primary_byte: expected 0x%02h, got 0x%02h", exp_w.primary_byte,
               got.primary_byte);
        errors++;
      end
      if (got.red_plane_byte !== exp_w.red_plane_byte) begin
        $error("red_plane_byte: expected 0x%02h, got 0x%02h", exp_w.red_plane_byte,
               got.red_plane_byte);
        errors++;
      end
    endfunction
  endclass

  logic                  clk_i;
  logic                  rst_ni       = 1'b0;
  logic                  cfg_we_i     = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_idx_i    = '0;
  logic [CFG_DATA_W-1:0] cfg_data_i   = '0;
  logic                  in_valid_i   = 1'b0;
  logic                  in_stall_o;
  logic [COORD_W-1:0]    pixel_x_i    = '0;
  logic [COORD_W-1:0]    pixel_y_i    = '0;
  logic [COLOR_W-1:0]    color_code_i = '0;
  logic                  out_valid_o;
  logic                  out_stall_i  = 1'b0;
  logic                  written_o;
  logic [OUT_ADDR_W-1:0] byte_address_o;
  logic [BYTE_W-1:0]     primary_byte_o;
  logic [BYTE_W-1:0]     red_plane_byte_o;

  frame_model         model = new();
  logic [COORD_W-1:0] last_x = '0;
  logic [COORD_W-1:0] last_y = '0;
  int unsigned        random_sent = 0;

  panel_pixel_packer dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_idx_i       (cfg_idx_i),
    .cfg_data_i      (cfg_data_i),
    .in_valid_i      (in_valid_i),
    .in_stall_o      (in_stall_o),
    .pixel_x_i       (pixel_x_i),
    .pixel_y_i       (pixel_y_i),
    .color_code_i    (color_code_i),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .written_o       (written_o),
    .byte_address_o  (byte_address_o),
    .primary_byte_o  (primary_byte_o),
    .red_plane_byte_o(red_plane_byte_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  // Mostly back-to-back, sometimes a short gap, rarely a long hole
  function automatic int unsigned gap_cycles();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 50) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Offer one pixel word and hold it until the block takes it.
  // Entered at a clock edge; returns at the edge where the word was accepted.
  task automatic send_pixel(logic [COORD_W-1:0] x, logic [COORD_W-1:0] y,
                            logic [COLOR_W-1:0] color);
    int unsigned gap;
    gap = gap_cycles();
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i   <= 1'b1;
    pixel_x_i    <= x;
    pixel_y_i    <= y;
    color_code_i <= color;
    do @(posedge clk_i); while (in_stall_o);
    model.note_pixel(x, y, color);
  endtask

  // Drop valid and wait until every pending word is back, then let the pipe settle
  task automatic drain_pipeline();
    in_valid_i <= 1'b0;
    while (model.expected_words.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(cfg_reg_e idx, logic [CFG_DATA_W-1:0] data);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    model.set_reg(idx, data);
    @(posedge clk_i);
  endtask

  // Reprogram the whole panel setup while the block is idle
  task automatic set_panel(logic [1:0] mode, rotation_e rot, logic [CFG_DATA_W-1:0] org_x,
                           logic [CFG_DATA_W-1:0] org_y, logic [COORD_W-1:0] w,
                           logic [COORD_W-1:0] h);
    drain_pipeline();
    write_reg(REG_MODE, CFG_DATA_W'(mode));
    write_reg(REG_ROTATION, CFG_DATA_W'(rot));
    write_reg(REG_ORIGIN_X, org_x);
    write_reg(REG_ORIGIN_Y, org_y);
    write_reg(REG_WIDTH, CFG_DATA_W'(w));
    write_reg(REG_HEIGHT, CFG_DATA_W'(h));
    cfg_we_i <= 1'b0;
  endtask

  task automatic random_panel();
    int unsigned r;
    logic [1:0]  mode;
    logic [12:0] ox, oy;
    logic [11:0] w, h;
    r = $urandom_range(99);
    mode = (r < 30) ? MODE_FLIP : (r < 60) ? MODE_ROT : (r < 96) ? MODE_PLANES : MODE_UNUSED;
    // Mostly small offsets so pixels land on the panel; a few anywhere in range
    r  = $urandom_range(99);
    ox = (r < 20) ? 13'h0 : (r < 80) ? 13'($urandom_range(80) - 40) : 13'($urandom_range(8191));
    r  = $urandom_range(99);
    oy = (r < 20) ? 13'h0 : (r < 80) ? 13'($urandom_range(80) - 40) : 13'($urandom_range(8191));
    // Mostly small panels keep the planes inside the red store; extremes now and then
    r = $urandom_range(99);
    w = (r < 10) ? 12'd2 : (r < 20) ? 12'd2048 : (r < 35) ? 12'($urandom_range(1, 16) * 2 + 1)
                                               : 12'($urandom_range(2, 512));
    r = $urandom_range(99);
    h = (r < 10) ? 12'd1 : (r < 20) ? 12'd2048 : 12'($urandom_range(1, 512));
    set_panel(mode, rotation_e'($urandom_range(3)), ox, oy, w, h);
  endtask

  // Aim most pixels at the visible window (plus a two-pixel fringe), some near
  // the previous one to hit the same byte again, the rest anywhere
  task automatic pick_pixel(output logic [COORD_W-1:0] x, output logic [COORD_W-1:0] y,
                            output logic [COLOR_W-1:0] color);
    longint      lo_x, hi_x, lo_y, hi_y, t;
    int unsigned r;
    case (model.mode)
      MODE_ROT: begin
        lo_x = model.width - model.height; hi_x = model.width - 1;
        lo_y = 0;                          hi_y = model.width - 1;
      end
      MODE_PLANES: begin
        lo_x = 0; hi_x = (model.rot[0] ? model.height : model.width) - 1;
        lo_y = 0; hi_y = (model.rot[0] ? model.width : model.height) - 1;
      end
      default: begin
        lo_x = 0; hi_x = model.width - 1;
        lo_y = 0; hi_y = model.height - 1;
      end
    endcase
    r = $urandom_range(99);
    if (r < 15) begin
      x = COORD_W'($urandom_range(4095));
      y = COORD_W'($urandom_range(4095));
    end else if (r < 35) begin
      x = last_x + COORD_W'($urandom_range(2)) - 12'd1;
      y = ($urandom_range(3) == 0) ? last_y + 12'd1 : last_y;
    end else begin
      t = lo_x - 2 + longint'($urandom_range(32'(hi_x - lo_x + 4)));
      t = t - model.org_x;
      x = (t >= 0 && t <= 4095) ? COORD_W'(t) : COORD_W'($urandom_range(4095));
      t = lo_y - 2 + longint'($urandom_range(32'(hi_y - lo_y + 4)));
      t = t - model.org_y;
      y = (t >= 0 && t <= 4095) ? COORD_W'(t) : COORD_W'($urandom_range(4095));
    end
    color  = ($urandom_range(1) == 0) ? COLOR_W'($urandom_range(2)) : COLOR_W'($urandom_range(15));
    last_x = x;
    last_y = y;
  endtask

  // Output side: free stretches of varying length, short stalls, a few long ones
  initial begin : out_backpressure
    int unsigned free_len, stall_len;
    forever begin
      free_len  = ($urandom_range(5) == 0) ? $urandom_range(50, 150) : $urandom_range(1, 8);
      stall_len = ($urandom_range(9) == 0) ? $urandom_range(10, 30) : $urandom_range(1, 3);
      repeat (free_len) @(posedge clk_i);
      out_stall_i <= 1'b1;
      repeat (stall_len) @(posedge clk_i);
      out_stall_i <= 1'b0;
    end
  end

  // Check every word the block hands over
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i)
      model.check_word({written_o, byte_address_o, primary_byte_o, red_plane_byte_o});
  end

  // Hang detector: count cycles in which no word moves on either side
  initial begin : watchdog
    int unsigned quiet;
    quiet = 0;
    forever begin
      @(posedge clk_i);
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) quiet = 0;
      else quiet++;
      if (quiet >= QUIET_LIMIT) begin
        $display("FAILURE");
        $finish;
      end
    end
  end

  initial begin : stimulus
    logic [COORD_W-1:0] x, y;
    logic [COLOR_W-1:0] color;
    int unsigned        phase_len;

    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Reset setup: 180-degree flip over 1200x1600; these wait out the zero sweep.
    // First two share the bottom-right byte, next two the top-left byte.
    send_pixel(12'd0, 12'd0, 4'hF);
    send_pixel(12'd1, 12'd0, 4'h5);
    send_pixel(12'd1199, 12'd1599, 4'hA);
    send_pixel(12'd1198, 12'd1599, 4'h3);
    send_pixel(12'd1200, 12'd5, 4'h1);     // clipped right
    send_pixel(12'd0, 12'd1600, 4'h2);     // clipped bottom
    send_pixel(12'd4095, 12'd4095, 4'hF);  // far corner of the field range

    // Rotated nibble mapping at the default size
    set_panel(MODE_ROT, ROT_0, 13'h0, 13'h0, WIDTH_RST, HEIGHT_RST);
    send_pixel(12'd0, 12'd0, 4'h9);
    send_pixel(12'd1199, 12'd1199, 4'h6);
    send_pixel(12'd0, 12'd1200, 4'h4);     // clipped

    // Bitplanes on a small panel: both corners under every rotation, all colors
    for (int r = 0; r < 4; r++) begin
      set_panel(MODE_PLANES, rotation_e'(r), 13'h0, 13'h0, 12'd64, 12'd48);
      send_pixel(12'd0, 12'd0, COLOR_W'(r));
      send_pixel(r[0] ? 12'd47 : 12'd63, r[0] ? 12'd63 : 12'd47, (r == 3) ? 4'hF : 4'h2);
    end
    send_pixel(12'd48, 12'd0, COLOR_BLACK);  // past the rotated width

    // A 2048x2048 panel in bitplane mode: one row inside the red store, one past it
    set_panel(MODE_PLANES, ROT_180, 13'h0, 13'h0, 12'd2048, 12'd2048);
    send_pixel(12'd0, 12'd255, COLOR_BLACK);
    send_pixel(12'd0, 12'd300, COLOR_BLACK);

    // Odd width: rows truncate to three bytes and the last column spills over
    set_panel(MODE_FLIP, ROT_0, 13'h0, 13'h0, 12'd7, 12'd3);
    send_pixel(12'd0, 12'd0, 4'hC);
    send_pixel(12'd6, 12'd2, 4'h7);

    // Origin at both ends of its range, then the unused mode
    set_panel(MODE_FLIP, ROT_0, 13'h1000, 13'h0FFF, 12'd2048, 12'd2048);
    send_pixel(12'd4095, 12'd0, 4'h7);
    set_panel(MODE_UNUSED, ROT_0, 13'h0, 13'h0, 12'd64, 12'd64);
    send_pixel(12'd10, 12'd10, 4'h3);

    // Random setups, each a burst of pixels; every switch waits for the pipe to empty
    while (random_sent < RANDOM_ITEMS) begin
      random_panel();
      phase_len = $urandom_range(20, 80);
      for (int i = 0; i < phase_len && random_sent < RANDOM_ITEMS; i++) begin
        pick_pixel(x, y, color);
        send_pixel(x, y, color);
        random_sent++;
      end
    end

    drain_pipeline();
    if (model.errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

// File: filelist.f
rtl/ppp_pkg.sv
rtl/ppp_ram.sv
rtl/ppp_front.sv
rtl/ppp_queue.sv
rtl/ppp_back.sv
rtl/panel_pixel_packer.sv
tb/panel_pixel_packer_test.sv
